// ----- src/trl_pkg.sv -----
// types and constants shared by the timestamped ring logger
package trl_pkg;

   localparam int CSR_W       = 7;
   localparam int COUNT_OUT_W = 7;
   localparam int SLOT_OUT_W  = 6;
   localparam int AGE_W       = 6;

   localparam logic [CSR_W-1:0] CSR_SLOTS_RESET = 7'd64;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_STORE = 2'd0;
   localparam cmd_type CMD_READ  = 2'd1;
   localparam cmd_type CMD_CLEAR = 2'd2;

   typedef struct packed {
      cmd_type           command;
      logic [5:0]        year;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [5:0]        second;
      logic signed [7:0] temperature;
      logic signed [7:0] humidity;
      logic [AGE_W-1:0]  age;
   } req_type;

   typedef struct packed {
      logic                   record_valid;
      logic [5:0]             out_year;
      logic [3:0]             out_month;
      logic [4:0]             out_day;
      logic [4:0]             out_hour;
      logic [5:0]             out_minute;
      logic [5:0]             out_second;
      logic signed [7:0]      out_temperature;
      logic signed [7:0]      out_humidity;
      logic [COUNT_OUT_W-1:0] record_count;
      logic [SLOT_OUT_W-1:0]  next_slot;
   } rsp_type;

   // stored layout: humidity 47:40, temperature 39:32, time word 31:0
   // (year 26, month 22, day 17, hour 12, minute 6, second 0)
   typedef struct packed {
      logic [7:0] humidity;
      logic [7:0] temperature;
      logic [5:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } record_type;

   // per-transaction status carried from the pointer logic to the result stage
   typedef struct packed {
      logic                   record_valid;
      logic [COUNT_OUT_W-1:0] record_count;
      logic [SLOT_OUT_W-1:0]  next_slot;
   } meta_type;

endpackage

// ----- src/timestamped_ring_logger_unit.sv -----
// top level of the timestamped ring logger
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_data (req_type)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_data (rsp_type)
//  csr     | in        | csr_wr_en            | csr_wr_data (slot count)
//
// one transaction per cycle while req_stall is low; each result is registered and
// appears in the cycle after acceptance, through the registered read port of the record store
// reset clears the pointer, the fill count and the output valid; slot count
// returns to 64; stored records are not cleared
// a stalled result holds its register; req_stall follows rsp_stall while it waits
module timestamped_ring_logger_unit
   import trl_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int COUNT_W = $clog2(SLOTS + 1);

   logic              accept;
   logic              mem_wr_en;
   logic [SLOT_W-1:0] mem_wr_addr;
   record_type        mem_wr_data;
   logic              mem_rd_en;
   logic [SLOT_W-1:0] mem_rd_addr;
   record_type        rd_data;
   meta_type          meta;
   meta_type          meta_ff;
   logic              rsp_valid_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   trl_ctrl #(
      .SLOTS   (SLOTS),
      .SLOT_W  (SLOT_W),
      .COUNT_W (COUNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req         (req_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .meta        (meta)
   );

   trl_mem #(
      .SLOTS  (SLOTS),
      .SLOT_W (SLOT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta;
      end
   end

   // record fields read as zero unless a read found a stored record
   always_comb begin
      rsp_data              = '0;
      rsp_data.record_valid = meta_ff.record_valid;
      rsp_data.record_count = meta_ff.record_count;
      rsp_data.next_slot    = meta_ff.next_slot;
      if (meta_ff.record_valid) begin
         rsp_data.out_year        = rd_data.year;
         rsp_data.out_month       = rd_data.month;
         rsp_data.out_day         = rd_data.day;
         rsp_data.out_hour        = rd_data.hour;
         rsp_data.out_minute      = rd_data.minute;
         rsp_data.out_second      = rd_data.second;
         rsp_data.out_temperature = rd_data.temperature;
         rsp_data.out_humidity    = rd_data.humidity;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/trl_mem.sv -----
// record store: one write port, one read port with registered read data
module trl_mem
   import trl_pkg::*;
#(
   parameter int SLOTS  = 64,
   parameter int SLOT_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  record_type        wr_data,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_addr,
   output record_type        rd_data
);

   record_type mem_ff [SLOTS];
   record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/trl_ctrl.sv -----
// slot count register, write pointer, fill count and read address logic
module trl_ctrl
   import trl_pkg::*;
#(
   parameter int SLOTS   = 64,
   parameter int SLOT_W  = 6,
   parameter int COUNT_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CSR_W-1:0]   csr_wr_data,
   input  logic               accept,
   input  req_type            req,
   output logic               mem_wr_en,
   output logic [SLOT_W-1:0]  mem_wr_addr,
   output record_type         mem_wr_data,
   output logic               mem_rd_en,
   output logic [SLOT_W-1:0]  mem_rd_addr,
   output meta_type           meta
);

   localparam int EFF_W = (COUNT_W > CSR_W) ? COUNT_W : CSR_W;
   localparam int IDX_W = EFF_W + 1;

   logic [CSR_W-1:0]   slots_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  slot_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               wrapped_ff;
   logic               wrapped_in;

   logic [EFF_W-1:0]   slots_eff;
   logic [EFF_W-1:0]   slot_next;
   logic [EFF_W-1:0]   count_ext;
   logic [EFF_W-1:0]   limit;
   logic [EFF_W-1:0]   age_clamped;
   logic [IDX_W-1:0]   back;
   logic [IDX_W-1:0]   slot_wide;
   logic [IDX_W-1:0]   rd_idx;
   logic               is_read;

   // slot count of 0 acts as 1, above the store depth acts as the depth
   always_comb begin
      slots_eff = EFF_W'(slots_ff);
      if (slots_ff == '0) begin
         slots_eff = EFF_W'(1);
      end else if (EFF_W'(slots_ff) > EFF_W'(SLOTS)) begin
         slots_eff = EFF_W'(SLOTS);
      end
   end

   assign slot_next = EFF_W'(slot_ff) + EFF_W'(1);
   assign count_ext = EFF_W'(count_ff);
   assign limit     = (count_ext < slots_eff) ? count_ext : slots_eff;
   assign is_read   = (req.command == CMD_READ);

   always_comb begin
      age_clamped = EFF_W'(req.age);
      if (age_clamped >= limit) begin
         age_clamped = limit - EFF_W'(1);
      end
   end

   // step back from the write slot, wrapping round the region in use
   assign back      = IDX_W'(age_clamped) + IDX_W'(1);
   assign slot_wide = IDX_W'(slot_ff);
   always_comb begin
      if (slot_wide >= back) begin
         rd_idx = slot_wide - back;
      end else begin
         rd_idx = slot_wide + IDX_W'(slots_eff) - back;
      end
   end

   always_comb begin
      slot_in    = slot_ff;
      count_in   = count_ff;
      wrapped_in = wrapped_ff;
      unique case (req.command)
         CMD_STORE: begin
            if (!wrapped_ff) begin
               count_in = count_ff + COUNT_W'(1);
            end
            if (slot_next >= slots_eff) begin
               slot_in    = '0;
               wrapped_in = 1'b1;
            end else begin
               slot_in = slot_next[SLOT_W-1:0];
            end
         end
         CMD_CLEAR: begin
            slot_in    = '0;
            count_in   = '0;
            wrapped_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff   <= CSR_SLOTS_RESET;
         slot_ff    <= '0;
         count_ff   <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            slots_ff <= csr_wr_data;
         end
         if (accept) begin
            slot_ff    <= slot_in;
            count_ff   <= count_in;
            wrapped_ff <= wrapped_in;
         end
      end
   end

   assign mem_wr_en   = accept && (req.command == CMD_STORE);
   assign mem_wr_addr = slot_ff;
   assign mem_wr_data = '{humidity:    req.humidity,
                          temperature: req.temperature,
                          year:        req.year,
                          month:       req.month,
                          day:         req.day,
                          hour:        req.hour,
                          minute:      req.minute,
                          second:      req.second};

   assign mem_rd_en   = accept && is_read;
   assign mem_rd_addr = rd_idx[SLOT_W-1:0];

   assign meta.record_valid = is_read && (count_ff != '0);
   assign meta.record_count = COUNT_OUT_W'(count_in);
   assign meta.next_slot    = SLOT_OUT_W'(slot_in);

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the timestamped ring logger unit
module testbench
   import trl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam cmd_type CMD_UNUSED = 2'd3;
   localparam int      LOG_SLOTS = 64;
   localparam int      RANDOM_PER_PHASE = 165;
   localparam int      LONG_HOLD_AT = 1200;
   localparam int      LONG_HOLD_CYCLES = 100;
   localparam int      REQ_BITS = $bits(req_type);

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   // commands waiting to be offered, replies owed by the block
   req_type queued_cmds [$];
   rsp_type replies_due [$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int accepted_count = 0;
   int field_faults = 0;
   int stim_faults = 0;

   // shadow of the log
   record_type       log_mem [LOG_SLOTS];
   bit               slot_written [LOG_SLOTS];
   int               head_slot;
   int               fill_count;
   bit               wrapped;
   logic [CSR_W-1:0] slot_setting;

   timestamped_ring_logger_unit #(.SLOTS(LOG_SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int slots_in_effect(input logic [CSR_W-1:0] setting);
      if (setting == 0) return 1;
      if (setting > LOG_SLOTS) return LOG_SLOTS;
      return int'(setting);
   endfunction

   // applies one command to the shadow log and returns the reply it owes
   function automatic rsp_type log_command(input req_type c);
      rsp_type    r;
      record_type rec;
      int         n;
      int         lim;
      int         a;
      int         idx;
      r = '0;
      n = slots_in_effect(slot_setting);
      case (c.command)
         CMD_STORE: begin
            rec.humidity = c.humidity;
            rec.temperature = c.temperature;
            rec.year = c.year;
            rec.month = c.month;
            rec.day = c.day;
            rec.hour = c.hour;
            rec.minute = c.minute;
            rec.second = c.second;
            // head may sit beyond a shrunk region; it is still written there
            log_mem[head_slot] = rec;
            slot_written[head_slot] = 1'b1;
            if (!wrapped) fill_count++;
            head_slot++;
            if (head_slot >= n) begin
               head_slot = 0;
               wrapped = 1'b1;
            end
         end
         CMD_READ: begin
            if (fill_count != 0) begin
               lim = (fill_count < n) ? fill_count : n;
               a = int'(c.age);
               if (a > lim - 1) a = lim - 1;
               idx = head_slot - (a + 1);
               if (idx < 0) idx += n;
               if (!slot_written[idx]) begin
                  $error("read reaches slot %0d that was never written", idx);
                  stim_faults++;
               end
               rec = log_mem[idx];
               r.record_valid = 1'b1;
               r.out_year = rec.year;
               r.out_month = rec.month;
               r.out_day = rec.day;
               r.out_hour = rec.hour;
               r.out_minute = rec.minute;
               r.out_second = rec.second;
               r.out_temperature = rec.temperature;
               r.out_humidity = rec.humidity;
            end
         end
         CMD_CLEAR: begin
            head_slot = 0;
            fill_count = 0;
            wrapped = 1'b0;
         end
         default: ;
      endcase
      r.record_count = COUNT_OUT_W'(fill_count);
      r.next_slot = SLOT_OUT_W'(head_slot);
      return r;
   endfunction

   // driver: offers queued commands and predicts each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         head_slot = 0;
         fill_count = 0;
         wrapped = 1'b0;
         slot_setting = CSR_SLOTS_RESET;
         for (int i = 0; i < LOG_SLOTS; i++) slot_written[i] = 1'b0;
      end else begin
         if (csr_wr_en) slot_setting = csr_wr_data;
         if (req_valid && !req_stall) begin
            replies_due.push_back(log_command(req_data));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= queued_cmds.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with one long hold-off to fill the block
   always @(posedge clock) begin : stall_gen
      int  hold_left;
      bit  hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && accepted_count >= LONG_HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left = LONG_HOLD_CYCLES;
         hold_done = 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic compare_field(input string fname, input logic signed [31:0] want_v,
                                input logic signed [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, got %0d", fname, want_v, got_v);
         field_faults++;
      end
   endtask

   // monitor: every accepted reply is checked against the oldest one owed
   always @(posedge clock) begin : reply_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            $error("reply transaction with no command outstanding");
            field_faults++;
         end else begin
            want = replies_due.pop_front();
            compare_field("record_valid", 32'(want.record_valid),
                          32'(rsp_data.record_valid));
            compare_field("out_year", 32'(want.out_year), 32'(rsp_data.out_year));
            compare_field("out_month", 32'(want.out_month), 32'(rsp_data.out_month));
            compare_field("out_day", 32'(want.out_day), 32'(rsp_data.out_day));
            compare_field("out_hour", 32'(want.out_hour), 32'(rsp_data.out_hour));
            compare_field("out_minute", 32'(want.out_minute), 32'(rsp_data.out_minute));
            compare_field("out_second", 32'(want.out_second), 32'(rsp_data.out_second));
            compare_field("out_temperature", 32'(want.out_temperature),
                          32'(rsp_data.out_temperature));
            compare_field("out_humidity", 32'(want.out_humidity),
                          32'(rsp_data.out_humidity));
            compare_field("record_count", 32'(want.record_count),
                          32'(rsp_data.record_count));
            compare_field("next_slot", 32'(want.next_slot), 32'(rsp_data.next_slot));
         end
      end
   end

   function automatic req_type make_cmd(input cmd_type op, input int yr, input int mo,
                                        input int dy, input int hr, input int mi,
                                        input int se, input int temp, input int hum,
                                        input int age);
      req_type c;
      c.command = op;
      c.year = 6'(yr);
      c.month = 4'(mo);
      c.day = 5'(dy);
      c.hour = 5'(hr);
      c.minute = 6'(mi);
      c.second = 6'(se);
      c.temperature = 8'(temp);
      c.humidity = 8'(hum);
      c.age = AGE_W'(age);
      return c;
   endfunction

   function automatic req_type random_cmd();
      logic [REQ_BITS-1:0] raw;
      req_type c;
      int roll;
      raw = REQ_BITS'({$urandom, $urandom});
      c = raw;
      roll = $urandom_range(999);
      if (roll < 480) c.command = CMD_STORE;
      else if (roll < 950) c.command = CMD_READ;
      else if (roll < 975) c.command = CMD_CLEAR;
      else c.command = CMD_UNUSED;
      // recent ages are the interesting ones, the rest exercise clamping
      if ($urandom_range(1) == 0) c.age = AGE_W'($urandom_range(7));
      return c;
   endfunction

   // checked mid-cycle so that the driver's updates at the edge have settled
   task automatic wait_drained();
      while (queued_cmds.size() != 0 || req_valid || replies_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_slot_count(input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CSR_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int plan [9];
      int cur_slots;
      plan = '{1, 0, 127, 5, 64, 2, 33, 17, 64};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      cur_slots = slots_in_effect(CSR_SLOTS_RESET);
      send_idle_pct = 18;
      stall_pct = 78;

      queued_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(CMD_READ, 63, 15, 31, 31, 63, 63, -1, -1, 63));
      queued_cmds.push_back(make_cmd(CMD_STORE, 63, 15, 31, 31, 63, 63, 127, -128, 63));
      queued_cmds.push_back(make_cmd(CMD_STORE, 0, 0, 0, 0, 0, 0, -128, 127, 0));
      queued_cmds.push_back(make_cmd(CMD_STORE, 42, 9, 21, 13, 37, 5, -1, -1, 0));
      queued_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      queued_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 2));
      queued_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 3));
      queued_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 63));
      queued_cmds.push_back(make_cmd(CMD_UNUSED, 63, 15, 31, 31, 63, 63, -1, -1, 63));
      queued_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(CMD_CLEAR, 63, 15, 31, 31, 63, 63, -1, -1, 63));
      queued_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(CMD_STORE, 1, 1, 1, 1, 1, 1, 1, 1, 0));
      queued_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 63));
      queued_cmds.push_back(make_cmd(CMD_STORE, 21, 6, 10, 22, 30, 59, 25, 60, 0));
      queued_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      wait_drained();

      for (int p = 0; p < 9; p++) begin
         if (p < 3) begin
            send_idle_pct = 18;
            stall_pct = 78;
         end else if (p < 6) begin
            send_idle_pct = 78;
            stall_pct = 18;
         end else begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         // growing the region over live records would expose unwritten slots
         if (slots_in_effect(CSR_W'(plan[p])) > cur_slots) begin
            queued_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            wait_drained();
         end
         repeat (2) @(posedge clock);
         write_slot_count(plan[p]);
         cur_slots = slots_in_effect(CSR_W'(plan[p]));
         for (int i = 0; i < RANDOM_PER_PHASE; i++) queued_cmds.push_back(random_cmd());
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (field_faults == 0 && stim_faults == 0 && replies_due.size() == 0) begin
         $display("** timestamped_ring_logger_unit: PASSED **");
      end else begin
         $display("** timestamped_ring_logger_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("** timestamped_ring_logger_unit: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
src/trl_pkg.sv
src/trl_mem.sv
src/trl_ctrl.sv
src/timestamped_ring_logger_unit.sv
tb/sv/testbench.sv
